// ===== src/tab_pkg.sv =====
// Package for the texture attribute bake block: payload structs, operation and
// register codes, fixed field widths and the output saturation function.
// Used by texture_attribute_bake_top; has no dependencies of its own.
package tab_pkg;

  // Default sizes of the tables and the attribute row.
  localparam int TABLE_DEPTH_DEF = 4096;
  localparam int COMPONENTS_DEF  = 3;

  // Saturation width of the baked components.
  localparam int ATTR_BITS = 16;

  // Fixed field widths.
  localparam int NUM_COMP   = 3;
  localparam int ATTR_W     = 16;
  localparam int IDX_W      = 12;
  localparam int DIST_W     = 24;
  localparam int BARY_W     = 16;
  localparam int WEIGHT_W   = BARY_W + 1;
  localparam int PROD_W     = WEIGHT_W + 1 + ATTR_W;
  localparam int SUM_W      = PROD_W + 2;
  localparam int FRAC_W     = BARY_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // Result queue; the depth must be a power of two.
  localparam int FIFO_DEPTH = 8;

  localparam int SAT_BITS = (ATTR_BITS < ATTR_W) ? ATTR_BITS : ATTR_W;
  localparam logic signed [SUM_W-1:0] SAT_HI =
    SUM_W'((longint'(1) << (SAT_BITS - 1)) - 1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

  typedef enum logic [1:0] {
    OP_CORNERS  = 2'd0,
    OP_ATTR_ROW = 2'd1,
    OP_QUERY    = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DISTANCE_LIMIT = 2'd0,
    CFG_FILL_LEVEL     = 2'd1,
    CFG_INTERPOLATE    = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]               operation;
    logic [IDX_W-1:0]         entry_index;
    logic [IDX_W-1:0]         corner_a;
    logic [IDX_W-1:0]         corner_b;
    logic [IDX_W-1:0]         corner_c;
    logic signed [ATTR_W-1:0] attr_x;
    logic signed [ATTR_W-1:0] attr_y;
    logic signed [ATTR_W-1:0] attr_z;
    logic [DIST_W-1:0]        sq_distance;
    logic [BARY_W-1:0]        bary_u;
    logic [BARY_W-1:0]        bary_v;
  } in_t;

  typedef struct packed {
    logic signed [ATTR_W-1:0] value_x;
    logic signed [ATTR_W-1:0] value_y;
    logic signed [ATTR_W-1:0] value_z;
    logic                     covered;
  } out_t;

  // Clamps a wide signed value to the signed range of SAT_BITS bits.
  function automatic logic signed [ATTR_W-1:0] saturate(
    input logic signed [SUM_W-1:0] x
  );
    logic signed [SUM_W-1:0] r;
    if (x > SAT_HI) begin
      r = SAT_HI;
    end else if (x < SAT_LO) begin
      r = SAT_LO;
    end else begin
      r = x;
    end
    return r[ATTR_W-1:0];
  endfunction

endpackage

// ===== src/tab_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM with a
// registered read (old data on a same-address write).
// No package dependencies.
module tab_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/texture_attribute_bake_top.sv =====
// Texture attribute bake: one item is taken per clock cycle while input
// ready is high, whatever its operation. Corner and attribute loads are
// written into their tables in the cycle of their transfer. A texel query
// does its corner table read at its transfer, then its attribute read and
// its multiply stage in turn, and the sum and saturate logic writes its
// result into the output queue from the multiply registers. The attribute
// table is held in three identical RAM copies so that all three vertex rows
// of a triangle are read in the same cycle. Input ready drops only while
// eight queries are in flight or waiting in the output queue. The tables are
// not cleared after reset; entries must be loaded before they are queried.
// Depends on tab_pkg and tab_ram.
module texture_attribute_bake_top #(
  parameter int TABLE_DEPTH = tab_pkg::TABLE_DEPTH_DEF,
  parameter int COMPONENTS  = tab_pkg::COMPONENTS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  tab_pkg::in_t                       in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output tab_pkg::out_t                      out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [tab_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [tab_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import tab_pkg::*;

  localparam int AW     = $clog2(TABLE_DEPTH);
  localparam int EW     = (AW > IDX_W) ? AW : IDX_W;
  localparam int NC     = (COMPONENTS < NUM_COMP) ? COMPONENTS : NUM_COMP;
  localparam int ROW_W  = NC * ATTR_W;
  localparam int PTR_W  = $clog2(FIFO_DEPTH);
  localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);

  function automatic logic in_range(input logic [IDX_W-1:0] i);
    return ({1'b0, EW'(i)} < (EW + 1)'(TABLE_DEPTH));
  endfunction

  function automatic logic [AW-1:0] to_addr(input logic [IDX_W-1:0] i);
    logic [EW-1:0] e;
    e = EW'(i);
    return e[AW-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [DIST_W-1:0]        dist_limit_q, dist_limit_d;
  logic signed [ATTR_W-1:0] fill_level_q, fill_level_d;
  logic                     interp_q, interp_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    dist_limit_d = dist_limit_q;
    fill_level_d = fill_level_q;
    interp_d     = interp_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_DISTANCE_LIMIT: dist_limit_d = cfg_data_i[DIST_W-1:0];
        CFG_FILL_LEVEL:     fill_level_d = cfg_data_i[ATTR_W-1:0];
        CFG_INTERPOLATE:    interp_d     = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_limit_q <= '0;
      fill_level_q <= '0;
      interp_q     <= 1'b1;
    end else begin
      dist_limit_q <= dist_limit_d;
      fill_level_q <= fill_level_d;
      interp_q     <= interp_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Transfer stage: table writes and the corner lookup
  // ---------------------------------------------------------------------------
  logic                 in_xfer, query_xfer, idx_ok;
  logic [AW-1:0]        idx_addr;
  logic [ATTR_W-1:0]    attr_in [NUM_COMP];
  logic [ROW_W-1:0]     attr_row_in;
  logic                 corner_we, attr_we;
  logic [3*IDX_W-1:0]   corner_rd;

  assign in_xfer    = in_valid_i && in_ready_o;
  assign query_xfer = in_xfer && (in_data_i.operation == OP_QUERY);
  assign idx_ok     = in_range(in_data_i.entry_index);
  assign idx_addr   = to_addr(in_data_i.entry_index);
  assign corner_we  = in_xfer && (in_data_i.operation == OP_CORNERS) && idx_ok;
  assign attr_we    = in_xfer && (in_data_i.operation == OP_ATTR_ROW) && idx_ok;

  assign attr_in[0] = in_data_i.attr_x;
  assign attr_in[1] = in_data_i.attr_y;
  assign attr_in[2] = in_data_i.attr_z;

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      attr_row_in[c*ATTR_W +: ATTR_W] = attr_in[c];
    end
  end

  tab_ram #(
    .WIDTH (3 * IDX_W),
    .DEPTH (TABLE_DEPTH)
  ) u_corner_ram (
    .clk_i   (clk_i),
    .we_i    (corner_we),
    .waddr_i (idx_addr),
    .wdata_i ({in_data_i.corner_c, in_data_i.corner_b, in_data_i.corner_a}),
    .raddr_i (idx_addr),
    .rdata_o (corner_rd)
  );

  logic                s1_valid_q;
  logic [AW-1:0]       s1_addr_q;
  logic                s1_idx_ok_q, s1_cov_q;
  logic [BARY_W-1:0]   s1_u_q, s1_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= query_xfer;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_addr_q   <= idx_addr;
    s1_idx_ok_q <= idx_ok;
    s1_cov_q    <= (in_data_i.sq_distance <= dist_limit_q);
    s1_u_q      <= in_data_i.bary_u;
    s1_v_q      <= in_data_i.bary_v;
  end

  // ---------------------------------------------------------------------------
  // Attribute lookup: three rows at the corners, or the triangle's own row
  // ---------------------------------------------------------------------------
  logic [IDX_W-1:0]        corner [NUM_COMP];
  logic [AW-1:0]           attr_raddr [NUM_COMP];
  logic [NUM_COMP-1:0]     row_ok;
  logic [ROW_W-1:0]        attr_rd [NUM_COMP];
  logic signed [WEIGHT_W:0] w_calc;
  logic [WEIGHT_W-1:0]     w_a;

  always_comb begin
    for (int k = 0; k < NUM_COMP; k++) begin
      corner[k] = corner_rd[k*IDX_W +: IDX_W];
    end
    if (interp_q) begin
      for (int k = 0; k < NUM_COMP; k++) begin
        attr_raddr[k] = to_addr(corner[k]);
        row_ok[k]     = s1_idx_ok_q && in_range(corner[k]);
      end
    end else begin
      for (int k = 0; k < NUM_COMP; k++) begin
        attr_raddr[k] = s1_addr_q;
        row_ok[k]     = 1'b0;
      end
      row_ok[0] = s1_idx_ok_q;
    end
  end

  // Weight of corner A is one minus u minus v, clamped at zero.
  assign w_calc = ((WEIGHT_W + 1)'(1) <<< FRAC_W)
                - $signed({2'b00, s1_u_q}) - $signed({2'b00, s1_v_q});
  assign w_a    = w_calc[WEIGHT_W] ? '0 : w_calc[WEIGHT_W-1:0];

  for (genvar k = 0; k < NUM_COMP; k++) begin : g_attr_bank
    tab_ram #(
      .WIDTH (ROW_W),
      .DEPTH (TABLE_DEPTH)
    ) u_attr_ram (
      .clk_i   (clk_i),
      .we_i    (attr_we),
      .waddr_i (idx_addr),
      .wdata_i (attr_row_in),
      .raddr_i (attr_raddr[k]),
      .rdata_o (attr_rd[k])
    );
  end

  logic                s2_valid_q, s2_cov_q;
  logic [NUM_COMP-1:0] s2_ok_q;
  logic [WEIGHT_W-1:0] s2_w_q;
  logic [BARY_W-1:0]   s2_u_q, s2_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_cov_q <= s1_cov_q;
    s2_ok_q  <= row_ok;
    s2_w_q   <= w_a;
    s2_u_q   <= s1_u_q;
    s2_v_q   <= s1_v_q;
  end

  // ---------------------------------------------------------------------------
  // Multiply stage
  // ---------------------------------------------------------------------------
  logic signed [ATTR_W-1:0] row_a [NC];
  logic signed [ATTR_W-1:0] row_b [NC];
  logic signed [ATTR_W-1:0] row_c [NC];
  logic signed [PROD_W-1:0] s3_pa_q [NC];
  logic signed [PROD_W-1:0] s3_pb_q [NC];
  logic signed [PROD_W-1:0] s3_pc_q [NC];
  logic signed [ATTR_W-1:0] s3_tri_q [NC];
  logic                     s3_valid_q, s3_cov_q;

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      row_a[c] = s2_ok_q[0] ? attr_rd[0][c*ATTR_W +: ATTR_W] : '0;
      row_b[c] = s2_ok_q[1] ? attr_rd[1][c*ATTR_W +: ATTR_W] : '0;
      row_c[c] = s2_ok_q[2] ? attr_rd[2][c*ATTR_W +: ATTR_W] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_cov_q <= s2_cov_q;
    for (int c = 0; c < NC; c++) begin
      s3_pa_q[c]  <= $signed({1'b0, s2_w_q}) * row_a[c];
      s3_pb_q[c]  <= $signed({1'b0, s2_u_q}) * row_b[c];
      s3_pc_q[c]  <= $signed({1'b0, s2_v_q}) * row_c[c];
      s3_tri_q[c] <= row_a[c];
    end
  end

  // ---------------------------------------------------------------------------
  // Sum, floor shift and saturation
  // ---------------------------------------------------------------------------
  logic signed [SUM_W-1:0]  sum [NC];
  logic signed [ATTR_W-1:0] res [NC];
  logic signed [ATTR_W-1:0] comp_out [NUM_COMP];
  out_t                     push_data;

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      sum[c] = SUM_W'(s3_pa_q[c]) + SUM_W'(s3_pb_q[c]) + SUM_W'(s3_pc_q[c]);
      if (!s3_cov_q) begin
        res[c] = saturate(SUM_W'(fill_level_q));
      end else if (interp_q) begin
        res[c] = saturate(sum[c] >>> FRAC_W);
      end else begin
        res[c] = saturate(SUM_W'(s3_tri_q[c]));
      end
    end
  end

  for (genvar c = 0; c < NUM_COMP; c++) begin : g_comp_out
    if (c < NC) begin : g_used
      assign comp_out[c] = res[c];
    end else begin : g_unused
      assign comp_out[c] = '0;
    end
  end

  assign push_data.value_x = comp_out[0];
  assign push_data.value_y = comp_out[1];
  assign push_data.value_z = comp_out[2];
  assign push_data.covered = s3_cov_q;

  // ---------------------------------------------------------------------------
  // Result queue and credit count
  // ---------------------------------------------------------------------------
  out_t             fifo_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] fifo_cnt_q, fifo_cnt_d;
  logic [CNT_W-1:0] pend_q, pend_d;
  logic             fifo_push, fifo_pop;

  assign fifo_push   = s3_valid_q;
  assign fifo_pop    = out_valid_o && out_ready_i;
  assign out_valid_o = (fifo_cnt_q != '0);
  assign out_data_o  = fifo_q[rd_ptr_q];

  // Pending counts every query from its transfer until its result transfer.
  assign in_ready_o = (pend_q < CNT_W'(FIFO_DEPTH));

  always_comb begin
    fifo_cnt_d = fifo_cnt_q + CNT_W'(fifo_push) - CNT_W'(fifo_pop);
    pend_d     = pend_q + CNT_W'(query_xfer) - CNT_W'(fifo_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
      pend_q     <= '0;
    end else begin
      fifo_cnt_q <= fifo_cnt_d;
      pend_q     <= pend_d;
      if (fifo_push) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (fifo_pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fifo_push) begin
      fifo_q[wr_ptr_q] <= push_data;
    end
  end

`ifndef NO_ASSERTIONS
  a_query_reaches_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    query_xfer |-> ##3 s3_valid_q)
    else $error("query did not reach the sum stage three cycles after transfer");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_push |-> (fifo_cnt_q < CNT_W'(FIFO_DEPTH)) || fifo_pop)
    else $error("result queue overflow");

  a_credit_covers_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_cnt_q <= pend_q)
    else $error("queued results exceed pending queries");
`endif

endmodule
